/* rtl/core/proximity_dedup_landmark_table_core_macros.svh */
// Assertion helpers shared by the landmark table RTL.
`ifndef PROXIMITY_DEDUP_LANDMARK_TABLE_CORE_MACROS_SVH
`define PROXIMITY_DEDUP_LANDMARK_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PDLT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pdlt same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define PDLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pdlt next-cycle check failed");

`endif

/* rtl/core/pdlt_pkg.sv */
`timescale 1ns / 1ps
package pdlt_pkg;

   localparam int CFG_BITS = 24;
   localparam int CAP_BITS = 24;   // axis difference saturates at 2^24
   localparam int SQ_BITS  = 2 * CAP_BITS;

   typedef enum logic [2:0] {
      V_NEW          = 3'd0,
      V_BAD_DEPTH    = 3'd1,
      V_OUT_OF_RANGE = 3'd2,
      V_DUPLICATE    = 3'd3,
      V_TABLE_FULL   = 3'd4
   } verdict_type;

   typedef enum logic {
      OP_RANGE = 1'b0,
      OP_MARK  = 1'b1
   } op_kind_type;

   typedef struct packed {
      logic        vld;
      op_kind_type kind;
   } dist_ctl_type;

   typedef struct packed {
      logic        vld;
      op_kind_type kind;
      logic        flag;   // range: too far; mark: too near
   } dist_res_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

/* rtl/core/pdlt_cell.sv */
`timescale 1ns / 1ps
// One landmark slot of the rotating ring.
module pdlt_cell #(
   parameter int COORD_BITS = 24
) (
   input  logic                         clock,
   input  pdlt_pkg::cell_ctl_type       ctl,
   input  logic [2:0][COORD_BITS-1:0]   load_pt,
   input  logic [2:0][COORD_BITS-1:0]   next_pt,
   output logic [2:0][COORD_BITS-1:0]   pt
);
   import pdlt_pkg::*;

   logic [2:0][COORD_BITS-1:0] pt_ff;
   logic [2:0][COORD_BITS-1:0] pt_in;

   // load and shift never coincide
   always_comb begin
      pt_in = pt_ff;
      if (ctl.load) begin
         pt_in = load_pt;
      end else if (ctl.shift) begin
         pt_in = next_pt;
      end
   end

   always_ff @(posedge clock) begin
      pt_ff <= pt_in;
   end

   assign pt = pt_ff;

endmodule

/* rtl/core/pdlt_dist.sv */
`timescale 1ns / 1ps
// Squared-distance compare, three stages: |diff|, square, sum + compare.
module pdlt_dist #(
   parameter int COORD_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pdlt_pkg::dist_ctl_type            op_ctl,
   input  logic [2:0][COORD_BITS-1:0]        pt_a,
   input  logic [2:0][COORD_BITS-1:0]        pt_b,
   input  logic [pdlt_pkg::SQ_BITS-1:0]      sep_sq,
   input  logic [pdlt_pkg::SQ_BITS-1:0]      rng_sq,
   output pdlt_pkg::dist_res_type            res,
   output logic                              busy
);
   import pdlt_pkg::*;

   localparam int DW    = COORD_BITS + 1;
   localparam int MW    = (DW > CAP_BITS + 1) ? DW : CAP_BITS + 1;
   localparam int SUM_W = SQ_BITS + 2;

   // stage 1
   dist_ctl_type               ctl_s1_ff;
   logic [2:0][CAP_BITS-1:0]   mag_s1_ff, mag_s1_in;
   logic                       sat_s1_ff;
   logic [2:0]                 sat_axis;

   // stage 2
   dist_ctl_type               ctl_s2_ff;
   logic [2:0][SQ_BITS-1:0]    sq_s2_ff;
   logic                       sat_s2_ff;

   // stage 3
   dist_res_type               res_ff, res_in;
   logic [SUM_W-1:0]           sum;

   for (genvar i = 0; i < 3; i++) begin : g_axis
      logic [DW-1:0] diff;
      logic [DW-1:0] mag;
      logic [MW-1:0] mag_ext;
      assign diff     = {pt_a[i][COORD_BITS-1], pt_a[i]} - {pt_b[i][COORD_BITS-1], pt_b[i]};
      assign mag      = diff[DW-1] ? (~diff + 1'b1) : diff;
      assign mag_ext  = MW'(mag);
      assign sat_axis[i]  = |mag_ext[MW-1:CAP_BITS];
      assign mag_s1_in[i] = mag_ext[CAP_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_s1_ff <= '0;
         ctl_s2_ff <= '0;
         res_ff    <= '0;
      end else begin
         ctl_s1_ff <= op_ctl;
         ctl_s2_ff <= ctl_s1_ff;
         res_ff    <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_s1_ff <= mag_s1_in;
      sat_s1_ff <= |sat_axis;
      for (int i = 0; i < 3; i++) begin
         sq_s2_ff[i] <= SQ_BITS'(mag_s1_ff[i]) * SQ_BITS'(mag_s1_ff[i]);
      end
      sat_s2_ff <= sat_s1_ff;
   end

   assign sum = SUM_W'(sq_s2_ff[0]) + SUM_W'(sq_s2_ff[1]) + SUM_W'(sq_s2_ff[2]);

   always_comb begin
      res_in.vld  = ctl_s2_ff.vld;
      res_in.kind = ctl_s2_ff.kind;
      if (ctl_s2_ff.kind == OP_RANGE) begin
         res_in.flag = sat_s2_ff || (sum > SUM_W'(rng_sq));
      end else begin
         res_in.flag = !sat_s2_ff && (sum < SUM_W'(sep_sq));
      end
   end

   assign res  = res_ff;
   assign busy = ctl_s1_ff.vld | ctl_s2_ff.vld | res_ff.vld;

endmodule

/* rtl/core/proximity_dedup_landmark_table_core.sv */
// A word with valid depth gets a range compare, then one compare per stored
// landmark as the ring turns past the single distance unit; a bad-depth word
// skips the scan. A new word is taken only once the last verdict is issued.
// Reset (synchronous, active high): landmark count to zero, separation to
// 100000 mm, range limit to 30000 mm. No clearing pass: slots at or above the
// count are never compared.
`timescale 1ns / 1ps
`include "proximity_dedup_landmark_table_core_macros.svh"
module proximity_dedup_landmark_table_core #(
   parameter int TABLE_DEPTH = 64,
   parameter int COORD_BITS  = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // candidate words
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [COORD_BITS-1:0]                req_cand_x,
   input  logic [COORD_BITS-1:0]                req_cand_y,
   input  logic [COORD_BITS-1:0]                req_cand_z,
   input  logic [COORD_BITS-1:0]                req_vehicle_x,
   input  logic [COORD_BITS-1:0]                req_vehicle_y,
   input  logic [COORD_BITS-1:0]                req_vehicle_z,
   input  logic                                 req_depth_valid,
   // verdict words
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output pdlt_pkg::verdict_type                rsp_verdict,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]     rsp_landmark_total,
   // register port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [2:0]                           paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);
   import pdlt_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   // ---------------- registers (config) ----------------
   logic [CFG_BITS-1:0] sep_ff, sep_in;
   logic [CFG_BITS-1:0] rng_ff, rng_in;
   logic [SQ_BITS-1:0]  sep_sq_ff, rng_sq_ff;
   logic                csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;

   // paddr[2] picks the register; low address bits are don't-care
   always_comb begin
      sep_in = sep_ff;
      rng_in = rng_ff;
      if (csr_wr) begin
         if (paddr[2]) begin
            rng_in = pwdata[CFG_BITS-1:0];
         end else begin
            sep_in = pwdata[CFG_BITS-1:0];
         end
      end
   end

   assign prdata = paddr[2] ? 32'(rng_ff) : 32'(sep_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff <= CFG_BITS'(100000);
         rng_ff <= CFG_BITS'(30000);
      end else begin
         sep_ff <= sep_in;
         rng_ff <= rng_in;
      end
   end

   // threshold squares, refreshed every cycle; settled long before first compare
   always_ff @(posedge clock) begin
      sep_sq_ff <= SQ_BITS'(sep_ff) * SQ_BITS'(sep_ff);
      rng_sq_ff <= SQ_BITS'(rng_ff) * SQ_BITS'(rng_ff);
   end

   // ---------------- control ----------------
   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           step_ff, step_in;      // 0: range op, k: slot k-1
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       bad_ff, bad_in;
   logic                       far_ff, far_in;
   logic                       dup_ff, dup_in;
   logic [2:0][COORD_BITS-1:0] cand_ff, cand_in;
   logic [2:0][COORD_BITS-1:0] veh_ff, veh_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   verdict_type                verdict_ff, verdict_in;
   logic [CNT_W-1:0]           total_ff, total_in;

   logic                       accept;
   logic                       decide;
   logic                       insert;
   logic                       full;
   logic                       scan_last;
   logic                       dist_busy;
   dist_res_type               dist_res;
   dist_ctl_type               dist_ctl;
   logic [2:0][COORD_BITS-1:0] dist_a;
   logic [2:0][COORD_BITS-1:0] ring_head;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign full      = (count_ff == CNT_W'(TABLE_DEPTH));
   assign scan_last = (state_ff == ST_SCAN) && (step_ff == CNT_W'(TABLE_DEPTH));

   // result may be produced only once the unit has drained and the output slot frees
   assign decide = (state_ff == ST_DRAIN) && !dist_busy && (!rsp_valid_ff || rsp_ready);
   assign insert = decide && !bad_ff && !far_ff && !dup_ff && !full;

   // step 0 checks vehicle range, steps 1..TABLE_DEPTH walk the ring head
   always_comb begin
      dist_ctl.vld  = (state_ff == ST_SCAN) && ((step_ff == '0) || (step_ff <= count_ff));
      dist_ctl.kind = (step_ff == '0) ? OP_RANGE : OP_MARK;
      dist_a        = (step_ff == '0) ? veh_ff : ring_head;
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cand_in  = cand_ff;
      veh_in   = veh_ff;
      bad_in   = bad_ff;
      far_in   = far_ff;
      dup_in   = dup_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cand_in  = {req_cand_z, req_cand_y, req_cand_x};
               veh_in   = {req_vehicle_z, req_vehicle_y, req_vehicle_x};
               bad_in   = !req_depth_valid;
               far_in   = 1'b0;
               dup_in   = 1'b0;
               step_in  = '0;
               state_in = req_depth_valid ? ST_SCAN : ST_DRAIN;
            end
         end
         ST_SCAN: begin
            step_in = step_ff + 1'b1;
            if (step_ff == CNT_W'(TABLE_DEPTH)) begin
               step_in  = step_ff;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (decide) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // collect compare outcomes as they leave the unit
      if (dist_res.vld && dist_res.flag) begin
         if (dist_res.kind == OP_RANGE) begin
            far_in = 1'b1;
         end else begin
            dup_in = 1'b1;
         end
      end
   end

   always_comb begin
      count_in     = count_ff + CNT_W'(insert);
      verdict_in   = verdict_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (decide) begin
         rsp_valid_in = 1'b1;
         total_in     = count_in;
         if (bad_ff) begin
            verdict_in = V_BAD_DEPTH;
         end else if (far_ff) begin
            verdict_in = V_OUT_OF_RANGE;
         end else if (dup_ff) begin
            verdict_in = V_DUPLICATE;
         end else if (full) begin
            verdict_in = V_TABLE_FULL;
         end else begin
            verdict_in = V_NEW;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         bad_ff       <= 1'b0;
         far_ff       <= 1'b0;
         dup_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         bad_ff       <= bad_in;
         far_ff       <= far_in;
         dup_ff       <= dup_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff    <= cand_in;
      veh_ff     <= veh_in;
      verdict_ff <= verdict_in;
      total_ff   <= total_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_verdict        = verdict_ff;
   assign rsp_landmark_total = total_ff;

   // ---------------- landmark ring ----------------
   // cell k hands its point to cell k-1 at every nonzero scan step; cell 0 feeds the unit.
   // TABLE_DEPTH shifts per scan bring every slot back to its home cell.
   logic [TABLE_DEPTH-1:0][2:0][COORD_BITS-1:0] ring_pt;

   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      localparam int NXT = (k + 1) % TABLE_DEPTH;
      cell_ctl_type ctl;
      assign ctl.shift = (state_ff == ST_SCAN) && (step_ff != '0);
      assign ctl.load  = insert && (count_ff == CNT_W'(k));
      pdlt_cell #(
         .COORD_BITS (COORD_BITS)
      ) u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .load_pt (cand_ff),
         .next_pt (ring_pt[NXT]),
         .pt      (ring_pt[k])
      );
   end

   assign ring_head = ring_pt[0];

   // ---------------- shared distance unit ----------------
   pdlt_dist #(
      .COORD_BITS (COORD_BITS)
   ) u_dist (
      .clock  (clock),
      .reset  (reset),
      .op_ctl (dist_ctl),
      .pt_a   (dist_a),
      .pt_b   (cand_ff),
      .sep_sq (sep_sq_ff),
      .rng_sq (rng_sq_ff),
      .res    (dist_res),
      .busy   (dist_busy)
   );

   // ---------------- checks ----------------
   `PDLT_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH))
   `PDLT_ASSERT_IMPL(a_idle_drained, clock, reset, req_ready, !dist_busy)
   `PDLT_ASSERT_IMPL(a_res_in_work, clock, reset, dist_res.vld, state_ff != ST_IDLE)
   `PDLT_ASSERT_NEXT(a_insert_count, clock, reset, insert, count_ff == $past(count_ff) + 1'b1)
   `PDLT_ASSERT_NEXT(a_scan_end, clock, reset, scan_last, state_ff == ST_DRAIN)

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
module tb;
   import pdlt_pkg::*;

   localparam int TABLE_DEPTH = 64;
   localparam int COORD_W     = 24;
   localparam int TOTAL_W     = $clog2(TABLE_DEPTH + 1);

   // register map: one 32-bit register every four bytes
   localparam logic [2:0] SEPARATION_ADDR = 3'd0;
   localparam logic [2:0] RANGE_ADDR      = 3'd4;

   localparam logic [23:0] SEPARATION_RESET = 24'd100000;
   localparam logic [23:0] RANGE_RESET      = 24'd30000;

   // one candidate word as the sender offers it; index 0/1/2 is x/y/z
   typedef struct {
      logic [COORD_W-1:0] cand [3];
      logic [COORD_W-1:0] veh [3];
      logic               dv;
   } cand_type;

   // one verdict word as the block should return it
   typedef struct {
      verdict_type        verdict;
      logic [TOTAL_W-1:0] total;
   } verdict_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [COORD_W-1:0]      req_cand_x = '0;
   logic [COORD_W-1:0]      req_cand_y = '0;
   logic [COORD_W-1:0]      req_cand_z = '0;
   logic [COORD_W-1:0]      req_vehicle_x = '0;
   logic [COORD_W-1:0]      req_vehicle_y = '0;
   logic [COORD_W-1:0]      req_vehicle_z = '0;
   logic                    req_depth_valid = 1'b0;

   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   verdict_type             rsp_verdict;
   logic [TOTAL_W-1:0]      rsp_landmark_total;

   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [2:0]              paddr = '0;
   logic [31:0]             pwdata = '0;
   logic [31:0]             prdata;
   logic                    pready;

   // Shadow of the block: landmark table, count and both thresholds.
   logic [COORD_W-1:0] mark_pos [TABLE_DEPTH][3];
   int                 mark_count = 0;
   logic [23:0]        separation_cfg = SEPARATION_RESET;
   logic [23:0]        range_cfg = RANGE_RESET;

   cand_type         pending_cands [$];   // words waiting for the driver
   verdict_word_type verdict_q [$];       // verdicts owed by the block, oldest first
   cand_type         cur;                 // word currently on the request port

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int err_count = 0;

   proximity_dedup_landmark_table_core #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .COORD_BITS (COORD_W)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cand_x        (req_cand_x),
      .req_cand_y        (req_cand_y),
      .req_cand_z        (req_cand_z),
      .req_vehicle_x     (req_vehicle_x),
      .req_vehicle_y     (req_vehicle_y),
      .req_vehicle_z     (req_vehicle_z),
      .req_depth_valid   (req_depth_valid),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_verdict       (rsp_verdict),
      .rsp_landmark_total(rsp_landmark_total),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #10_000_000;
      $display("proximity_dedup_landmark_table_core verification failed");
      $finish;
   end

   task automatic note_mismatch(input string msg);
      err_count++;
      $display("[%0t] MISMATCH %s", $realtime, msg);
   endtask

   // ---------------------------------------------------------------------
   // Verdict predictor
   // ---------------------------------------------------------------------

   // Exact squared distance; any axis gap of 2^24 or more saturates.
   function automatic logic [63:0] gap_sq(input logic [COORD_W-1:0] a [3],
                                          input logic [COORD_W-1:0] b [3]);
      logic [63:0] acc;
      longint      d;
      int          i;
      acc = '0;
      for (i = 0; i < 3; i++) begin
         d = longint'($signed(a[i])) - longint'($signed(b[i]));
         if (d < 0) d = -d;
         if (d >= (longint'(1) << CAP_BITS)) return '1;
         acc += 64'(d * d);
      end
      return acc;
   endfunction

   // Runs one accepted word through the checks in block order:
   // depth, range, separation against every stored mark, then table room.
   function automatic verdict_word_type judge_candidate(input cand_type c);
      verdict_word_type w;
      logic [63:0]      sep_sq;
      logic [63:0]      rng_sq;
      bit               dup;
      int               i;
      sep_sq = 64'(separation_cfg) * 64'(separation_cfg);
      rng_sq = 64'(range_cfg) * 64'(range_cfg);
      dup = 1'b0;
      if (!c.dv) begin
         w.verdict = V_BAD_DEPTH;
      end else if (gap_sq(c.veh, c.cand) > rng_sq) begin
         w.verdict = V_OUT_OF_RANGE;
      end else begin
         for (i = 0; i < mark_count; i++) begin
            if (gap_sq(mark_pos[i], c.cand) < sep_sq) dup = 1'b1;
         end
         if (dup) begin
            w.verdict = V_DUPLICATE;
         end else if (mark_count >= TABLE_DEPTH) begin
            w.verdict = V_TABLE_FULL;
         end else begin
            mark_pos[mark_count] = c.cand;
            mark_count++;
            w.verdict = V_NEW;
         end
      end
      w.total = TOTAL_W'(mark_count);
      return w;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   function automatic longint jitter(input longint span);
      longint s;
      s = (span > (longint'(1) << 24)) ? (longint'(1) << 24) : span;
      if (s <= 0) return 0;
      return longint'($urandom_range(0, 32'(2 * s))) - s;
   endfunction

   function automatic longint rand_coord();
      return longint'($signed(COORD_W'($urandom)));
   endfunction

   // Mostly well-formed words aimed at the decision edges: near a stored
   // mark at about the separation, at about the range limit, or fresh
   // points inside range. A small share is pure noise or bad depth.
   function automatic cand_type make_candidate();
      cand_type c;
      longint   sep;
      longint   rng;
      longint   mag;
      longint   v [3];
      longint   p [3];
      int       pick;
      int       ax;
      int       k;
      int       i;
      sep  = longint'(separation_cfg);
      rng  = longint'(range_cfg);
      pick = $urandom_range(0, 99);
      ax   = $urandom_range(0, 2);
      c.dv = 1'b1;
      for (i = 0; i < 3; i++) begin
         v[i] = rand_coord();
         p[i] = v[i];
      end
      if (pick < 10) begin
         // noise; the upper part always carries bad depth
         for (i = 0; i < 3; i++) p[i] = rand_coord();
         c.dv = (pick < 6) ? 1'($urandom_range(0, 1)) : 1'b0;
      end else if (pick < 40 && mark_count > 0) begin
         k = $urandom_range(0, mark_count - 1);
         for (i = 0; i < 3; i++) p[i] = longint'($signed(mark_pos[k][i]));
         case ($urandom_range(0, 3))
            0: begin
               mag = sep - 1;
            end
            1: begin
               mag = sep;
            end
            2: begin
               mag = sep + 1;
            end
            default: begin
               mag = longint'($urandom_range(0, 32'(sep)));
            end
         endcase
         if ($urandom_range(0, 1)) mag = -mag;
         p[ax] += mag;
         if ($urandom_range(0, 3) == 0) begin
            for (i = 0; i < 3; i++) p[i] += jitter(2);
         end
         // vehicle close enough that the range check mostly passes
         for (i = 0; i < 3; i++) begin
            v[i] = $urandom_range(0, 1) ? p[i] + jitter(rng / 2) : p[i];
         end
      end else if (pick < 55) begin
         case ($urandom_range(0, 2))
            0: begin
               mag = rng - 1;
            end
            1: begin
               mag = rng;
            end
            default: begin
               mag = rng + 1;
            end
         endcase
         if ($urandom_range(0, 1)) mag = -mag;
         p[ax] = v[ax] + mag;
      end else begin
         if (mark_count > 0 && $urandom_range(0, 1)) begin
            k = $urandom_range(0, mark_count - 1);
            for (i = 0; i < 3; i++) begin
               v[i] = longint'($signed(mark_pos[k][i])) + jitter(2 * sep);
            end
         end
         for (i = 0; i < 3; i++) p[i] = v[i] + jitter(rng / 2);
      end
      for (i = 0; i < 3; i++) begin
         c.cand[i] = COORD_W'(p[i]);
         c.veh[i]  = COORD_W'(v[i]);
      end
      return c;
   endfunction

   function automatic void queue_direct(input longint cx, input longint cy,
                                        input longint cz, input longint vx,
                                        input longint vy, input longint vz,
                                        input logic dv);
      cand_type c;
      c.cand[0] = COORD_W'(cx);
      c.cand[1] = COORD_W'(cy);
      c.cand[2] = COORD_W'(cz);
      c.veh[0]  = COORD_W'(vx);
      c.veh[1]  = COORD_W'(vy);
      c.veh[2]  = COORD_W'(vz);
      c.dv      = dv;
      pending_cands = {pending_cands, c};
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: offers the next pending word, idles at random, and
   // predicts each word on the edge that accepts it.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) verdict_q = {verdict_q, judge_candidate(cur)};
         if (!req_valid || req_ready) begin
            if (pending_cands.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               cur = pending_cands.pop_front();
               req_cand_x      <= cur.cand[0];
               req_cand_y      <= cur.cand[1];
               req_cand_z      <= cur.cand[2];
               req_vehicle_x   <= cur.veh[0];
               req_vehicle_y   <= cur.veh[1];
               req_vehicle_z   <= cur.veh[2];
               req_depth_valid <= cur.dv;
               req_valid       <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Verdict monitor: checks each accepted word against the oldest
   // prediction, field by field, and stalls at random.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      verdict_word_type owed;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               note_mismatch($sformatf("verdict word %0d with nothing owed",
                                       rsp_verdict));
            end else begin
               owed = verdict_q.pop_front();
               if (rsp_verdict !== owed.verdict)
                  note_mismatch($sformatf("verdict got %0d want %0d",
                                          rsp_verdict, owed.verdict));
               if (rsp_landmark_total !== owed.total)
                  note_mismatch($sformatf("landmark_total got %0d want %0d",
                                          rsp_landmark_total, owed.total));
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Register port
   // ---------------------------------------------------------------------
   task automatic csr_write(input logic [2:0] addr, input logic [23:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= {8'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (pready !== 1'b1) note_mismatch("pready low in access cycle");
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == SEPARATION_ADDR) separation_cfg = value;
      else if (addr == RANGE_ADDR) range_cfg = value;
   endtask

   // prdata is checked mid access cycle, when it has settled
   task automatic csr_check(input logic [2:0] addr, input logic [23:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      if (prdata[23:0] !== value)
         note_mismatch($sformatf("register %0d read %0d want %0d",
                                 addr, prdata[23:0], value));
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Sender holds off until every owed verdict is back. Sampled on the
   // falling edge so the driver's updates of this cycle are visible.
   task automatic wait_quiet();
      do @(negedge clock);
      while (pending_cands.size() != 0 || req_valid || verdict_q.size() != 0);
   endtask

   task automatic run_phase(input logic [23:0] sep, input logic [23:0] rng,
                            input int send_pct, input int stall_pct, input int n);
      int i;
      wait_quiet();
      csr_write(SEPARATION_ADDR, sep);
      csr_write(RANGE_ADDR, rng);
      csr_check(SEPARATION_ADDR, sep);
      csr_check(RANGE_ADDR, rng);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      for (i = 0; i < n; i++) begin
         // feed just ahead of the driver so targeting uses a fresh table
         while (pending_cands.size() >= 2) @(negedge clock);
         pending_cands = {pending_cands, make_candidate()};
         if (i == n / 2) wait_quiet();
      end
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      csr_check(SEPARATION_ADDR, SEPARATION_RESET);
      csr_check(RANGE_ADDR, RANGE_RESET);

      // Directed words, reset thresholds (separation 100000, range 30000).
      queue_direct(8388607, 8388607, 8388607, -8388608, -8388608, -8388608, 1'b0);
      queue_direct(0, 0, 0, 0, 0, 0, 1'b0);                   // bad depth
      queue_direct(30001, 0, 0, 0, 0, 0, 1'b1);               // just past range
      queue_direct(30000, 0, 0, 0, 0, 0, 1'b1);               // range edge: stored
      queue_direct(0, 0, 0, 0, 0, 0, 1'b1);                   // duplicate
      queue_direct(-10000, -20000, 20000, 0, 0, 0, 1'b1);     // 3-axis range edge
      queue_direct(130000, 0, 0, 130000, 0, 0, 1'b1);         // separation edge: new
      queue_direct(-69999, 0, 0, -69999, 0, 0, 1'b1);         // 1 mm inside separation
      queue_direct(8388607, 8388607, 8388607, 8388607, 8388607, 8388607, 1'b1);
      queue_direct(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608, 1'b1);
      queue_direct(8388607, 8388607, 8388607, -8388608, -8388608, -8388608, 1'b1);
      queue_direct(8388607, -8388608, 0, -8388608, 8388607, 0, 1'b1);
      queue_direct(8388607, 8388607, 8288607, 8388607, 8388607, 8288607, 1'b1);
      queue_direct(8388607, 8388607, 8288608, 8388607, 8388607, 8288608, 1'b1);

      // Random phases: threshold settings crossed with idle patterns.
      run_phase(24'd5000, 24'd200000, 0, 0, 240);
      run_phase(24'hFFFFFF, 24'hFFFFFF, 56, 0, 240);
      run_phase(24'd300, 24'd0, 0, 56, 200);
      run_phase(24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)),
                11, 11, 240);
      run_phase(24'd0, 24'hFFFFFF, 0, 0, 170);
      run_phase(24'd12000, 24'd1000, 56, 0, 180);
      run_phase(24'd1, 24'hFFFFFF, 0, 56, 180);

      wait_quiet();
      // a stray extra word would show up within one pass of the ring
      repeat (TABLE_DEPTH + 16) @(posedge clock);
      if (err_count == 0) begin
         $display("proximity_dedup_landmark_table_core verification clean");
      end else begin
         $display("proximity_dedup_landmark_table_core verification failed");
      end
      $finish;
   end

endmodule
